>>> rtl/core/ssh_pkg.sv
// Package for the streaming substring highlighter.
// Field widths, operation codes and configuration register indexes.
// Used by the channel interfaces and the top level; depends on nothing.
package ssh_pkg;

    localparam int PT_W            = 21;
    localparam int SLOT_W          = 5;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;
    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH  = 2'd2;

endpackage

>>> rtl/core/ssh_if.sv
// Channel interfaces of the streaming substring highlighter: input items,
// result items and configuration writes. Depends on ssh_pkg.
interface ssh_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssh_pkg::OP_W-1:0]    op;
    logic [ssh_pkg::PT_W-1:0]    code_point;
    logic [ssh_pkg::PT_W-1:0]    folded_point;
    logic                        is_letter;
    logic [ssh_pkg::SLOT_W-1:0]  slot;
    modport source (output valid, op, code_point, folded_point, is_letter, slot,
                    input ready);
    modport sink   (input valid, op, code_point, folded_point, is_letter, slot,
                    output ready);
endinterface

interface ssh_out_if;
    logic                     valid;
    logic                     ready;
    logic [ssh_pkg::PT_W-1:0] out_point;
    logic                     highlighted;
    logic                     last;
    modport source (output valid, out_point, highlighted, last, input ready);
    modport sink   (input valid, out_point, highlighted, last, output ready);
endinterface

interface ssh_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ssh_pkg::CFG_IDX_W-1:0]  index;
    logic [ssh_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/stream_substring_highlighter.sv
// Streaming substring highlighter, top level. Depends on ssh_pkg and ssh_if.
// Echoes text characters and flags those that belong to a stored pattern match.
//
// A pattern load or an unknown operation is finished when it is accepted. A
// text or end item is accepted first; then, for text with a non-empty
// pattern, a fallback search runs in which each character comparison passes
// through a read state and a compare state (the shared comparator waits on
// the registered read of the two-port pattern memory): H+1 comparisons when
// the H held characters and the new one still form a prefix, up to
// L*(L+1)/2 comparisons for a pattern of length L in the worst case. Each
// released character is then sent when the output is free, the release loop
// is left, and a final state holds the new character or echoes it once the
// output is free, returning the block to ready. Input ready is low while an
// item is in progress; configuration writes are always taken.
module stream_substring_highlighter #(
    parameter int PATTERN_MAX = ssh_pkg::PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssh_cfg_if.sink     i_cfg,
    ssh_in_if.sink      i_in,
    ssh_out_if.source   o_out
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_REL, S_TAIL
    } t_state;

    t_state r_state;

    // Configuration
    logic                           r_ic, r_ww;
    logic [ssh_pkg::CFG_DATA_W-1:0] r_plen;

    // Pattern memory and letter flags
    logic [ssh_pkg::PT_W-1:0] r_pat_mem [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   r_pat_let;
    logic [ssh_pkg::PT_W-1:0] r_rd_a, r_rd_b;

    // Held characters, a circular buffer
    logic [ssh_pkg::PT_W-1:0] r_held_pt [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   r_held_let;
    logic [IW-1:0]            r_head;
    logic [CW-1:0]            r_count;
    logic                     r_bl;

    // Item in progress
    logic [ssh_pkg::OP_W-1:0] r_op;
    logic [ssh_pkg::PT_W-1:0] r_cp, r_key;
    logic                     r_let;
    logic [CW-1:0]            r_orig, r_s, r_j, r_relcnt;
    logic                     r_found, r_flag, r_ovr;

    // Output register
    logic                     r_ovalid, r_ohl, r_olast;
    logic [ssh_pkg::PT_W-1:0] r_opt;

    logic [CW-1:0]            len, rest, addr_a, addr_b;
    logic [IW-1:0]            lm1, head_nx, tail;
    logic [SW-1:0]            tail_sum;
    logic                     in_acc, in_let, held_gt, held_eq, ww_fail, good;
    logic                     out_free, emit_cp, out_set;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.valid       = r_ovalid;
    assign o_out.out_point   = r_opt;
    assign o_out.highlighted = r_ohl;
    assign o_out.last        = r_olast;
    assign out_free          = !r_ovalid || o_out.ready;

    always_comb begin
        if (32'(r_plen) > PATTERN_MAX) begin
            len = CW'(PATTERN_MAX);
        end else begin
            len = CW'(r_plen);
        end
        lm1      = IW'(len - CW'(1));
        in_let   = (i_in.op == ssh_pkg::OP_END) ? 1'b0 : i_in.is_letter;
        held_gt  = r_count > len;
        held_eq  = (r_count == len) && (len != '0);
        ww_fail  = r_ww && ((r_bl && r_pat_let[0]) || (r_pat_let[lm1] && in_let));
        rest     = r_orig - r_s;
        if (r_j == '0) begin
            addr_a = rest;
            addr_b = '0;
            good   = (r_rd_a == r_key);
        end else begin
            addr_a = r_s + r_j - CW'(1);
            addr_b = r_j - CW'(1);
            good   = (r_rd_a == r_rd_b);
        end
        head_nx  = (32'(r_head) == PATTERN_MAX - 1) ? '0 : r_head + IW'(1);
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= SW'(PATTERN_MAX)) begin
            tail = IW'(tail_sum - SW'(PATTERN_MAX));
        end else begin
            tail = IW'(tail_sum);
        end
        emit_cp  = (r_op == ssh_pkg::OP_TEXT) && ((len == '0) || !r_found);
        // A new transfer is loaded into the output register this cycle.
        out_set  = out_free &&
                   (((r_state == S_REL) && (r_relcnt != '0)) ||
                    ((r_state == S_TAIL) && (r_op != ssh_pkg::OP_END) && emit_cp));
    end

    // Pattern memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.op == ssh_pkg::OP_LOAD) && (32'(i_in.slot) < PATTERN_MAX)) begin
            r_pat_mem[IW'(i_in.slot)] <= r_ic ? i_in.folded_point : i_in.code_point;
        end
        r_rd_a <= r_pat_mem[addr_a[IW-1:0]];
        r_rd_b <= r_pat_mem[addr_b[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ic     <= 1'b0;
            r_ww     <= 1'b0;
            r_plen   <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_bl     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    ssh_pkg::CFG_IGNORE_CASE: r_ic   <= i_cfg.data[0];
                    ssh_pkg::CFG_WHOLE_WORDS: r_ww   <= i_cfg.data[0];
                    ssh_pkg::CFG_PAT_LENGTH:  r_plen <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready && !out_set) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_in.op;
                        r_cp  <= i_in.code_point;
                        r_key <= r_ic ? i_in.folded_point : i_in.code_point;
                        r_let <= in_let;
                        r_s   <= '0;
                        r_j   <= '0;
                        r_found <= 1'b0;
                        if (i_in.op == ssh_pkg::OP_LOAD) begin
                            if (32'(i_in.slot) < PATTERN_MAX) begin
                                r_pat_let[IW'(i_in.slot)] <= i_in.is_letter;
                            end
                        end else if (i_in.op == ssh_pkg::OP_TEXT ||
                                     i_in.op == ssh_pkg::OP_END) begin
                            // A complete or oversized held run is released first.
                            r_flag   <= held_eq && !ww_fail;
                            r_ovr    <= held_eq;
                            r_orig   <= (held_gt || held_eq) ? '0 : r_count;
                            r_relcnt <= (held_gt || held_eq || i_in.op == ssh_pkg::OP_END)
                                        ? r_count : '0;
                            if (i_in.op == ssh_pkg::OP_TEXT && len != '0) begin
                                r_state <= S_SRCH_RD;
                            end else begin
                                r_state <= S_REL;
                            end
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    // Shift s keeps the last orig-s held characters as a prefix.
                    if (!good) begin
                        if (r_s == r_orig) begin
                            r_found  <= 1'b0;
                            r_relcnt <= r_relcnt + r_s;
                            r_state  <= S_REL;
                        end else begin
                            r_s     <= r_s + CW'(1);
                            r_j     <= '0;
                            r_state <= S_SRCH_RD;
                        end
                    end else if (r_j == rest) begin
                        r_found  <= 1'b1;
                        r_relcnt <= r_relcnt + r_s;
                        r_state  <= S_REL;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_REL: begin
                    if (r_relcnt == '0) begin
                        r_state <= S_TAIL;
                    end else if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_opt    <= r_held_pt[r_head];
                        r_ohl    <= r_flag;
                        r_olast  <= (r_relcnt == CW'(1)) && !emit_cp;
                        r_head   <= head_nx;
                        r_count  <= r_count - CW'(1);
                        r_relcnt <= r_relcnt - CW'(1);
                        if ((r_relcnt == CW'(1)) && r_ovr) begin
                            r_bl <= r_pat_let[lm1];
                        end else begin
                            r_bl <= r_held_let[r_head];
                        end
                    end
                end
                S_TAIL: begin
                    if (r_op == ssh_pkg::OP_END) begin
                        r_bl    <= 1'b0;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else if (emit_cp) begin
                        if (out_free) begin
                            r_ovalid <= 1'b1;
                            r_opt    <= r_cp;
                            r_ohl    <= 1'b0;
                            r_olast  <= 1'b1;
                            r_bl     <= r_let;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_held_pt[tail]  <= r_cp;
                        r_held_let[tail] <= r_let;
                        r_count          <= r_count + CW'(1);
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
